// File: rtl/cch_pkg.sv
package cch_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RESEND    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

    localparam logic [15:0] RESEND_RST    = 16'd1000;
    localparam logic [15:0] KEEPALIVE_RST = 16'd1000;
    localparam logic [31:0] TIMEOUT_RST   = 32'd5000;

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_PACKET = 2'd1;
    localparam logic [1:0] KIND_CONN   = 2'd2;
    localparam logic [1:0] KIND_WRITE  = 2'd3;

    localparam logic [2:0] PKT_CHALLENGE = 3'd0;
    localparam logic [2:0] PKT_KEEPALIVE = 3'd1;
    localparam logic [2:0] PKT_PAYLOAD   = 3'd2;
    localparam logic [2:0] PKT_DISC      = 3'd3;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_DISC = 3'd1;
    localparam logic [2:0] PH_REQ  = 3'd2;
    localparam logic [2:0] PH_RESP = 3'd3;
    localparam logic [2:0] PH_CONN = 3'd4;

    localparam logic [2:0] SEND_NONE = 3'd0;
    localparam logic [2:0] SEND_REQ  = 3'd1;
    localparam logic [2:0] SEND_RESP = 3'd2;
    localparam logic [2:0] SEND_KA   = 3'd3;
    localparam logic [2:0] SEND_DISC = 3'd4;
    localparam logic [2:0] SEND_PAY  = 3'd5;

    typedef struct packed {
        logic [15:0] resend_interval;
        logic [15:0] keepalive_interval;
        logic [31:0] connect_timeout;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  send_request;
        logic        deliver_payload;
        logic [2:0]  conn_state;
        logic [31:0] client_ident;
        logic [63:0] token_seq;
    } result_t;

endpackage

// File: rtl/cch_cfg.sv
module cch_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cch_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cch_pkg::CFG_DATA_W-1:0]   cfg_data,
    output cch_pkg::cfg_t                    cfg
);

    cch_pkg::cfg_t cfg_reg;
    cch_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                cch_pkg::CFG_RESEND:    cfg_next.resend_interval    = cfg_data[15:0];
                cch_pkg::CFG_KEEPALIVE: cfg_next.keepalive_interval = cfg_data[15:0];
                cch_pkg::CFG_TIMEOUT:   cfg_next.connect_timeout    = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.resend_interval    <= cch_pkg::RESEND_RST;
            cfg_reg.keepalive_interval <= cch_pkg::KEEPALIVE_RST;
            cfg_reg.connect_timeout    <= cch_pkg::TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/cch_core.sv
module cch_core
#(
    parameter int TIME_BITS = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  cch_pkg::cfg_t         cfg,
    input  logic [1:0]            kind,
    input  logic [TIME_BITS-1:0]  now,
    input  logic [2:0]            packet_type,
    input  logic [63:0]           challenge_seq,
    input  logic [31:0]           assigned_id,
    output cch_pkg::result_t      res
);

    logic [2:0]           phase_reg, phase_next, phase_cur;
    logic [TIME_BITS-1:0] nst_reg, nst_next;
    logic [TIME_BITS-1:0] dl_reg, dl_next;
    logic [31:0]          id_reg, id_next;
    logic [63:0]          seq_reg, seq_next;

    logic [TIME_BITS:0]   dl_sum, tx_sum;
    logic [TIME_BITS-1:0] dl_sat, tx_sat, tx_base;
    logic [15:0]          tx_step;
    logic [2:0]           send;
    logic                 deliver;

    assign phase_cur = (phase_reg > cch_pkg::PH_CONN) ? cch_pkg::PH_IDLE : phase_reg;

    // saturating time sums: entry deadline, and send time advance
    assign tx_base = (kind == cch_pkg::KIND_WRITE) ? now : nst_reg;
    assign tx_step = (phase_cur == cch_pkg::PH_CONN) ? cfg.keepalive_interval
                                                     : cfg.resend_interval;
    assign tx_sum  = {1'b0, tx_base} + {{(TIME_BITS-15){1'b0}}, tx_step};
    assign dl_sum  = {1'b0, now} + {{(TIME_BITS-31){1'b0}}, cfg.connect_timeout};
    assign tx_sat  = tx_sum[TIME_BITS] ? '1 : tx_sum[TIME_BITS-1:0];
    assign dl_sat  = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];

    always_comb
    begin
        phase_next = phase_cur;
        nst_next   = nst_reg;
        dl_next    = dl_reg;
        id_next    = id_reg;
        seq_next   = seq_reg;
        send       = cch_pkg::SEND_NONE;
        deliver    = 1'b0;
        case (kind)
            cch_pkg::KIND_TICK:
            begin
                if (phase_cur == cch_pkg::PH_REQ || phase_cur == cch_pkg::PH_RESP ||
                    phase_cur == cch_pkg::PH_DISC)
                begin
                    if (now >= dl_reg)
                    begin
                        phase_next = (phase_cur == cch_pkg::PH_DISC) ? cch_pkg::PH_IDLE
                                                                     : cch_pkg::PH_DISC;
                        nst_next   = now;
                        dl_next    = dl_sat;
                    end
                    else if (now >= nst_reg)
                    begin
                        nst_next = tx_sat;
                        case (phase_cur)
                            cch_pkg::PH_REQ:  send = cch_pkg::SEND_REQ;
                            cch_pkg::PH_RESP: send = cch_pkg::SEND_RESP;
                            default:          send = cch_pkg::SEND_DISC;
                        endcase
                    end
                end
                else if (phase_cur == cch_pkg::PH_CONN && now >= nst_reg)
                begin
                    nst_next = tx_sat;
                    send     = cch_pkg::SEND_KA;
                end
            end
            cch_pkg::KIND_PACKET:
            begin
                if (phase_cur == cch_pkg::PH_REQ && packet_type == cch_pkg::PKT_CHALLENGE)
                begin
                    seq_next   = challenge_seq;
                    phase_next = cch_pkg::PH_RESP;
                    nst_next   = now;
                    dl_next    = dl_sat;
                end
                else if (phase_cur == cch_pkg::PH_RESP &&
                         packet_type == cch_pkg::PKT_KEEPALIVE)
                begin
                    id_next    = assigned_id;
                    phase_next = cch_pkg::PH_CONN;
                    nst_next   = now;
                    dl_next    = dl_sat;
                end
                else if (phase_cur == cch_pkg::PH_CONN &&
                         packet_type == cch_pkg::PKT_PAYLOAD)
                begin
                    deliver = 1'b1;
                end
                else if (phase_cur == cch_pkg::PH_CONN && packet_type == cch_pkg::PKT_DISC)
                begin
                    phase_next = cch_pkg::PH_DISC;
                    nst_next   = now;
                    dl_next    = dl_sat;
                end
            end
            cch_pkg::KIND_CONN:
            begin
                if (phase_cur == cch_pkg::PH_IDLE)
                begin
                    phase_next = cch_pkg::PH_REQ;
                    nst_next   = now;
                    dl_next    = dl_sat;
                end
            end
            default:
            begin
                if (phase_cur == cch_pkg::PH_CONN)
                begin
                    nst_next = tx_sat;
                    send     = cch_pkg::SEND_PAY;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cch_pkg::PH_IDLE;
            nst_reg   <= '0;
            dl_reg    <= '0;
            id_reg    <= '0;
            seq_reg   <= '0;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            nst_reg   <= nst_next;
            dl_reg    <= dl_next;
            id_reg    <= id_next;
            seq_reg   <= seq_next;
        end
    end

    assign res.send_request    = send;
    assign res.deliver_payload = deliver;
    assign res.conn_state      = phase_next;
    assign res.client_ident    = id_next;
    assign res.token_seq       = seq_next;

endmodule

// File: rtl/client_connect_handshake_fsm.sv
// channel | handshake          | beat contents
// in      | in_valid, in_stall | kind, now, packet_type, challenge_seq, assigned_id
// out     | out_valid, out_stall | send_request, deliver_payload, conn_state,
//         |                    | client_ident, token_seq
// cfg     | cfg_we             | cfg_index, cfg_data
//
// One beat per cycle sustained while out_stall is low; each result is registered before it reaches the output.
// The state update sits between the input register and the result register.
// Reset clears state to idle, times and stored ids to zero, registers to defaults.
// in_stall rises only when the input register is full and the result register is held.
module client_connect_handshake_fsm
#(
    parameter int TIME_BITS = 48
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cch_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cch_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          kind,
    input  logic [TIME_BITS-1:0]                now,
    input  logic [2:0]                          packet_type,
    input  logic [63:0]                         challenge_seq,
    input  logic [31:0]                         assigned_id,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          send_request,
    output logic                                deliver_payload,
    output logic [2:0]                          conn_state,
    output logic [31:0]                         client_ident,
    output logic [63:0]                         token_seq
);

    cch_pkg::cfg_t        cfg;
    cch_pkg::result_t     res;
    cch_pkg::result_t     out_reg;

    logic                 in_vld_reg, in_vld_next;
    logic                 out_vld_reg, out_vld_next;
    logic [1:0]           kind_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [2:0]           ptype_reg;
    logic [63:0]          seq_reg;
    logic [31:0]          id_reg;
    logic                 advance;
    logic                 take;

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign take     = in_valid && !in_stall;

    assign in_vld_next  = take || (in_vld_reg && !advance);
    assign out_vld_next = advance || (out_vld_reg && out_stall);

    cch_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cch_core #(.TIME_BITS(TIME_BITS)) u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (advance),
        .cfg           (cfg),
        .kind          (kind_reg),
        .now           (now_reg),
        .packet_type   (ptype_reg),
        .challenge_seq (seq_reg),
        .assigned_id   (id_reg),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg  <= kind;
            now_reg   <= now;
            ptype_reg <= packet_type;
            seq_reg   <= challenge_seq;
            id_reg    <= assigned_id;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign out_valid       = out_vld_reg;
    assign send_request    = out_reg.send_request;
    assign deliver_payload = out_reg.deliver_payload;
    assign conn_state      = out_reg.conn_state;
    assign client_ident    = out_reg.client_ident;
    assign token_seq       = out_reg.token_seq;

`ifndef SYNTHESIS
    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("result beat lost after advance");

    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_vld_reg && out_vld_reg))
        else $error("input stalled with room downstream");

    a_pay_in_conn: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && (send_request == cch_pkg::SEND_PAY || send_request == cch_pkg::SEND_KA))
        |-> (conn_state == cch_pkg::PH_CONN))
        else $error("payload or keep-alive send outside connected");

    a_deliver_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && deliver_payload)
        |-> (conn_state == cch_pkg::PH_CONN && send_request == cch_pkg::SEND_NONE))
        else $error("delivery with send or outside connected");
`endif

endmodule

// File: tb/sv/tb_client_connect_handshake_fsm.sv
module tb_client_connect_handshake_fsm;
    timeunit 1ns;
    timeprecision 1ps;

    import cch_pkg::*;

    localparam int TB = 48;
    localparam logic [TB-1:0] T_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [2:0] PKT_UNKNOWN = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_BEATS = 1150;
    localparam int RAND_SEGMENTS = 8;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            kind = KIND_TICK;
    logic [TB-1:0]         now = '0;
    logic [2:0]            packet_type = PKT_CHALLENGE;
    logic [63:0]           challenge_seq = '0;
    logic [31:0]           assigned_id = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [2:0]            send_request;
    logic                  deliver_payload;
    logic [2:0]            conn_state;
    logic [31:0]           client_ident;
    logic [63:0]           token_seq;

    client_connect_handshake_fsm #(.TIME_BITS(TB)) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .now             (now),
        .packet_type     (packet_type),
        .challenge_seq   (challenge_seq),
        .assigned_id     (assigned_id),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .send_request    (send_request),
        .deliver_payload (deliver_payload),
        .conn_state      (conn_state),
        .client_ident    (client_ident),
        .token_seq       (token_seq)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // connection tracker state
    logic [2:0]    conn_phase = PH_IDLE;
    logic [TB-1:0] send_due = '0;
    logic [TB-1:0] give_up_at = '0;
    logic [31:0]   held_id = '0;
    logic [63:0]   held_seq = '0;
    logic [15:0]   resend_gap = RESEND_RST;
    logic [15:0]   keepalive_gap = KEEPALIVE_RST;
    logic [31:0]   handshake_timeout = TIMEOUT_RST;

    result_t       expected_q[$];
    int unsigned   fail_count = 0;
    int unsigned   beats_sent = 0;
    int unsigned   results_seen = 0;
    int unsigned   config_sets = 0;
    int unsigned   fallbacks = 0;
    int unsigned   deliveries = 0;
    int unsigned   sends_by_code[8] = '{default: 0};
    int unsigned   cycle_count = 0;
    int unsigned   stall_left = 0;
    bit            feed_calm = 1'b0;
    bit            sink_calm = 1'b0;

    function automatic logic [TB-1:0] time_add(input logic [TB-1:0] a, input logic [31:0] b);
        logic [TB:0] s;
        s = {1'b0, a} + {{(TB - 31){1'b0}}, b};
        return s[TB] ? T_MAX : s[TB-1:0];
    endfunction

    function automatic void enter_phase(input logic [2:0] p, input logic [TB-1:0] t);
        conn_phase = p;
        send_due   = t;
        give_up_at = time_add(t, handshake_timeout);
    endfunction

    function automatic result_t step_connection(input logic [1:0] k, input logic [TB-1:0] t,
                                                input logic [2:0] p, input logic [63:0] s,
                                                input logic [31:0] id);
        result_t r;
        logic [2:0] snd;
        logic dlv;
        snd = SEND_NONE;
        dlv = 1'b0;
        case (k)
            KIND_TICK:
            begin
                if (conn_phase == PH_REQ || conn_phase == PH_RESP || conn_phase == PH_DISC)
                begin
                    if (t >= give_up_at)
                    begin
                        fallbacks++;
                        enter_phase(conn_phase == PH_DISC ? PH_IDLE : PH_DISC, t);
                    end
                    else if (t >= send_due)
                    begin
                        send_due = time_add(send_due, {16'b0, resend_gap});
                        snd = (conn_phase == PH_REQ) ? SEND_REQ
                            : (conn_phase == PH_RESP) ? SEND_RESP : SEND_DISC;
                    end
                end
                else if (conn_phase == PH_CONN && t >= send_due)
                begin
                    send_due = time_add(send_due, {16'b0, keepalive_gap});
                    snd = SEND_KA;
                end
            end
            KIND_PACKET:
            begin
                if (conn_phase == PH_REQ && p == PKT_CHALLENGE)
                begin
                    held_seq = s;
                    enter_phase(PH_RESP, t);
                end
                else if (conn_phase == PH_RESP && p == PKT_KEEPALIVE)
                begin
                    held_id = id;
                    enter_phase(PH_CONN, t);
                end
                else if (conn_phase == PH_CONN && p == PKT_PAYLOAD)
                    dlv = 1'b1;
                else if (conn_phase == PH_CONN && p == PKT_DISC)
                    enter_phase(PH_DISC, t);
            end
            KIND_CONN:
            begin
                if (conn_phase == PH_IDLE)
                    enter_phase(PH_REQ, t);
            end
            default:
            begin
                if (conn_phase == PH_CONN)
                begin
                    send_due = time_add(t, {16'b0, keepalive_gap});
                    snd = SEND_PAY;
                end
            end
        endcase
        sends_by_code[snd]++;
        deliveries += dlv;
        r.send_request    = snd;
        r.deliver_payload = dlv;
        r.conn_state      = conn_phase;
        r.client_ident    = held_id;
        r.token_seq       = held_seq;
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (feed_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [TB-1:0] rand_time();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TB-1:0];
    endfunction

    task automatic send_beat(input logic [1:0] k, input logic [TB-1:0] t, input logic [2:0] p,
                             input logic [63:0] s, input logic [31:0] id);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        now           <= t;
        packet_type   <= p;
        challenge_seq <= s;
        assigned_id   <= id;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q.push_back(step_connection(k, t, p, s, id));
        beats_sent++;
    endtask

    // hold off the sender until every outstanding beat has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] resend_w, input logic [31:0] keep_w,
                              input logic [31:0] timeout_w);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RESEND;
        cfg_data  <= resend_w;
        @(posedge clk);
        cfg_index <= CFG_KEEPALIVE;
        cfg_data  <= keep_w;
        @(posedge clk);
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= timeout_w;
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_we <= 1'b0;
        resend_gap        = resend_w[15:0];
        keepalive_gap     = keep_w[15:0];
        handshake_timeout = timeout_w;
        config_sets++;
    endtask

    task automatic test_handshake();
        send_beat(KIND_TICK,   48'd0,    PKT_CHALLENGE, '0, '0);
        send_beat(KIND_WRITE,  48'd50,   PKT_CHALLENGE, '0, '0);
        send_beat(KIND_CONN,   48'd100,  PKT_CHALLENGE, '0, '0);
        send_beat(KIND_TICK,   48'd100,  PKT_CHALLENGE, '0, '0);
        send_beat(KIND_TICK,   48'd1099, PKT_CHALLENGE, '0, '0);
        send_beat(KIND_PACKET, 48'd1100, PKT_KEEPALIVE, '0, 32'h1234_5678);
        send_beat(KIND_PACKET, 48'd1200, PKT_CHALLENGE, '1, '0);
        send_beat(KIND_TICK,   48'd1200, PKT_CHALLENGE, '0, '0);
        send_beat(KIND_PACKET, 48'd1400, PKT_KEEPALIVE, '0, '1);
        send_beat(KIND_WRITE,  48'd1600, PKT_CHALLENGE, '0, '0);
        send_beat(KIND_TICK,   48'd2600, PKT_CHALLENGE, '0, '0);
        send_beat(KIND_PACKET, 48'd2700, PKT_PAYLOAD,   '0, '0);
        send_beat(KIND_PACKET, 48'd2800, PKT_UNKNOWN,   '0, '0);
        send_beat(KIND_CONN,   48'd2900, PKT_CHALLENGE, '0, '0);
        send_beat(KIND_PACKET, 48'd3000, PKT_DISC,      '0, '0);
        send_beat(KIND_TICK,   48'd3000, PKT_CHALLENGE, '0, '0);
        send_beat(KIND_TICK,   48'd8000, PKT_CHALLENGE, '0, '0);
    endtask

    task automatic test_timeouts();
        send_beat(KIND_CONN,   48'd10000, PKT_CHALLENGE, '0, '0);
        send_beat(KIND_TICK,   48'd15000, PKT_CHALLENGE, '0, '0);
        send_beat(KIND_TICK,   48'd20000, PKT_CHALLENGE, '0, '0);
        send_beat(KIND_CONN,   48'd30000, PKT_CHALLENGE, '0, '0);
        send_beat(KIND_PACKET, 48'd30001, PKT_CHALLENGE, 64'h0123_4567_89AB_CDEF, '0);
        send_beat(KIND_TICK,   48'd35001, PKT_CHALLENGE, '0, '0);
        send_beat(KIND_TICK,   48'd40001, PKT_CHALLENGE, '0, '0);
    endtask

    task automatic test_zero_timeout();
        set_config(32'd0, 32'd0, 32'd0);
        send_beat(KIND_CONN, 48'd40000, PKT_CHALLENGE, '0, '0);
        send_beat(KIND_TICK, 48'd40000, PKT_CHALLENGE, '0, '0);
        send_beat(KIND_TICK, 48'd40000, PKT_CHALLENGE, '0, '0);
    endtask

    task automatic test_time_saturation();
        set_config(32'hFFFF_FFFF, 32'h5A5A_FFFF, 32'hFFFF_FFFF);
        send_beat(KIND_CONN, T_MAX - 5, PKT_CHALLENGE, '0, '0);
        send_beat(KIND_TICK, T_MAX - 5, PKT_CHALLENGE, '0, '0);
        send_beat(KIND_TICK, T_MAX,     PKT_CHALLENGE, '0, '0);
        send_beat(KIND_TICK, T_MAX,     PKT_CHALLENGE, '0, '0);
        send_beat(KIND_TICK, '0,        PKT_CHALLENGE, '0, '0);
    endtask

    task automatic test_random_traffic();
        int seg;
        int n;
        int unsigned r;
        int unsigned step_cap;
        logic [TB-1:0] t;
        logic [1:0] k;
        logic [2:0] p;
        for (seg = 0; seg < RAND_SEGMENTS; seg++)
        begin
            case (seg)
                1: set_config(32'd1, 32'd1, 32'd1);
                2: set_config(32'hFFFF_0000, 32'hABCD_0000, 32'd0);
                3: set_config(32'h0000_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                default: set_config({16'($urandom), 16'($urandom_range(1, 20))},
                                    {16'($urandom), 16'($urandom_range(1, 20))},
                                    $urandom_range(10, 200));
            endcase
            feed_calm = (seg % 3 == 2);
            sink_calm = (seg % 4 == 1);
            step_cap  = (seg == 3) ? 40000 : handshake_timeout / 4 + 2;
            t = (seg == 3) ? T_MAX - $urandom_range(0, 1 << 22) : rand_time();
            for (n = 0; n < RANDOM_BEATS / RAND_SEGMENTS; n++)
            begin
                if ($urandom_range(0, 99) < 2)
                    t = rand_time();
                else
                    t = time_add(t, $urandom_range(0, step_cap));
                k = KIND_TICK;
                p = PKT_CHALLENGE;
                r = $urandom_range(0, 99);
                if (r < 12)
                begin
                    k = 2'($urandom);
                    p = 3'($urandom);
                end
                else
                begin
                    case (conn_phase)
                        PH_IDLE:
                            if (r < 70)
                                k = KIND_CONN;
                        PH_REQ:
                            if (r < 40)
                                k = KIND_PACKET;
                        PH_RESP:
                            if (r < 40)
                            begin
                                k = KIND_PACKET;
                                p = PKT_KEEPALIVE;
                            end
                        PH_CONN:
                            if (r < 30)
                                k = KIND_WRITE;
                            else if (r < 45)
                            begin
                                k = KIND_PACKET;
                                p = PKT_PAYLOAD;
                            end
                            else if (r < 52)
                            begin
                                k = KIND_PACKET;
                                p = PKT_DISC;
                            end
                        default: ;
                    endcase
                end
                send_beat(k, t, p, {$urandom, $urandom}, $urandom);
            end
        end
    endtask

    // receiver back-pressure: mostly short stalls, a few long ones
    always @(posedge clk)
    begin
        int unsigned r;
        if (!rst_n || sink_calm)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b1;
                if (r < 92)
                    stall_left = $urandom_range(0, 2);
                else if (r < 99)
                    stall_left = $urandom_range(3, 10);
                else
                    stall_left = $urandom_range(20, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {send_request, deliver_payload, conn_state, client_ident, token_seq};
            results_seen++;
            if (expected_q.size() == 0)
                note_failure($sformatf("unexpected beat: send %0d deliver %0d state %0d",
                                       send_request, deliver_payload, conn_state));
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                    note_failure($sformatf({"beat %0d mismatch: exp send %0d dlv %0d state %0d",
                        " id %h seq %h / got send %0d dlv %0d state %0d id %h seq %h"},
                        results_seen, want.send_request, want.deliver_payload,
                        want.conn_state, want.client_ident, want.token_seq,
                        got.send_request, got.deliver_payload, got.conn_state,
                        got.client_ident, got.token_seq));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, expected_q.size());
            $display("** client_connect_handshake_fsm: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_handshake();
        test_timeouts();
        test_zero_timeout();
        test_time_saturation();
        test_random_traffic();
        settle();
        repeat (10) @(posedge clk);
        $display("%0d beats under %0d register settings, %0d results checked, %0d timeouts",
                 beats_sent, config_sets, results_seen, fallbacks);
        $display("asked: %0d request %0d response %0d keep-alive %0d disconnect %0d payload, %0d delivered",
                 sends_by_code[SEND_REQ], sends_by_code[SEND_RESP], sends_by_code[SEND_KA],
                 sends_by_code[SEND_DISC], sends_by_code[SEND_PAY], deliveries);
        if (fail_count == 0)
            $display("** client_connect_handshake_fsm: PASSED **");
        else
            $display("** client_connect_handshake_fsm: FAILED **");
        $finish;
    end

endmodule
